/* design/locked_sequence_task_queues_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the task queue unit
// Immediate-style wrappers around concurrent assertions, clocked on clk and
// disabled during rst. They expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LOCKED_SEQUENCE_TASK_QUEUES_UNIT_DEFINES_SVH
`define LOCKED_SEQUENCE_TASK_QUEUES_UNIT_DEFINES_SVH

`ifndef SYNTH
// cond holds at every edge
`define LSTQ_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// ante implies cons in the same cycle
`define LSTQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// ante implies cons in the next cycle
`define LSTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LSTQ_ASSERT(lbl, cond, msg)
`define LSTQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define LSTQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* design/lstq_pkg.sv */
// ----------------------------------------------------------------------------
// lstq_pkg
// Operation codes, register indexes and field widths of the task queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lstq_pkg;

  localparam int OP_W       = 3;
  localparam int QID_W      = 8;
  localparam int HANDLE_W   = 16;
  localparam int ACTIVE_W   = 3;
  localparam int CAP_REG_W  = 5;
  localparam int CAP_REGS   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam logic [CAP_REG_W-1:0] CAP_RESET    = 5'd16;
  localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET = 3'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_SPACE  = 3'd1,
    OP_READY  = 3'd2,
    OP_TAKE   = 3'd3,
    OP_FINISH = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED = 3'd0,
    CFG_ACTIVE  = 3'd1,
    CFG_CAP_Q0  = 3'd2,
    CFG_CAP_Q1  = 3'd3,
    CFG_CAP_Q2  = 3'd4,
    CFG_CAP_Q3  = 3'd5
  } cfg_idx_t;

endpackage

`default_nettype wire

/* design/locked_sequence_task_queues_unit.sv */
// ----------------------------------------------------------------------------
// locked_sequence_task_queues_unit
// Bounded FIFO queues of task handles with per-queue capacity and lock bit.
// Queue 0 is unordered; a take on any other queue locks it until finish.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                      | payload
//  s_axis   | in  | tvalid/tready                  | op, queue_id, task_handle
//  m_axis   | out | tvalid/tready                  | ok, out_handle
//  cfg      | in  | cfg_we (no wait, no read-back) | cfg_index, cfg_wdata
//
// One item per cycle sustained while the output does not stall; each item's result
// goes through the queue state update plus RAM read, then the output register.
// Per-queue head, count and lock live in flops and are updated in the accept
// cycle, so back-to-back items on the same queue see each other.
// rst is synchronous; it resets config, counts, heads and locks, not the RAM.
// A stalled output holds one result and one item in flight, then s_axis_tready
// drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "locked_sequence_task_queues_unit_defines.svh"

module locked_sequence_task_queues_unit
  import lstq_pkg::*;
#(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [2:0] operation, [10:3] queue_id, [26:11] task_handle, [31:27] zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [0] ok, [16:1] out_handle, [23:17] zero
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_REG_W) ? CNT_W : CAP_REG_W;
  localparam int SUM_W = CNT_W + 1;
  localparam int TOTAL = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;

  localparam logic [QID_W-1:0] NQ_LIMIT  = QID_W'(NUM_QUEUES);
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
  localparam logic [HW:0]      DEPTH_HD  = (HW + 1)'(QUEUE_DEPTH);

  // configuration
  logic                 enabled;
  logic [ACTIVE_W-1:0]  active_queues;
  logic [CAP_REG_W-1:0] cap_reg [CAP_REGS];

  // per-queue state
  logic [HW-1:0]    head   [NUM_QUEUES];
  logic [CNT_W-1:0] count  [NUM_QUEUES];
  logic             locked [NUM_QUEUES];
  logic [CMP_W-1:0] cap_q  [NUM_QUEUES];

  // pipeline
  logic            s1_valid, s1_ok, s1_take;
  logic [QW-1:0]   s1_qi;
  logic            out_valid, out_ok;
  logic [HANDLE_W-1:0] out_handle;
  logic            s1_adv, accept;

  // decode
  op_t             op;
  logic [QID_W-1:0] queue_id;
  logic [HANDLE_W-1:0] task_handle;
  logic [QID_W-1:0] act_ext, act_eff;
  logic            hit;
  logic [QW-1:0]   qi;
  logic [CNT_W-1:0] cnt_sel;
  logic [HW-1:0]   head_sel;
  logic            lock_sel, has_room, nonempty;
  logic            res_ok, do_add, do_take, do_finish;
  logic [SUM_W-1:0] tail_sum;
  logic [HW-1:0]   tail_slot;
  logic [HW:0]     head_inc;
  logic [HW-1:0]   head_next;
  logic [AW-1:0]   ram_addr;
  logic [HANDLE_W-1:0] ram_rdata;

  assign op          = op_t'(s_axis_tdata[2:0]);
  assign queue_id    = s_axis_tdata[10:3];
  assign task_handle = s_axis_tdata[26:11];

  // effective capacity per queue: register where one exists, clamped to depth
  for (genvar gi = 0; gi < NUM_QUEUES; gi++) begin : g_cap
    logic [CMP_W-1:0] cap_raw;
    if (gi < CAP_REGS) begin : g_reg
      assign cap_raw = CMP_W'(cap_reg[gi]);
    end else begin : g_fixed
      assign cap_raw = DEPTH_CMP;
    end
    assign cap_q[gi] = (cap_raw > DEPTH_CMP) ? DEPTH_CMP : cap_raw;
  end

  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    act_ext   = QID_W'(active_queues);
    act_eff   = (act_ext > NQ_LIMIT) ? NQ_LIMIT : act_ext;
    hit       = enabled && (queue_id < act_eff);
    qi        = queue_id[QW-1:0];
    cnt_sel   = count[qi];
    head_sel  = head[qi];
    lock_sel  = locked[qi];
    has_room  = CMP_W'(cnt_sel) < cap_q[qi];
    nonempty  = cnt_sel != '0;

    // ring wrap for a depth that need not be a power of two
    tail_sum  = SUM_W'(head_sel) + SUM_W'(cnt_sel);
    if (tail_sum >= DEPTH_SUM) begin
      tail_sum = tail_sum - DEPTH_SUM;
    end
    tail_slot = tail_sum[HW-1:0];
    head_inc  = (HW + 1)'(head_sel) + (HW + 1)'(1);
    head_next = (head_inc == DEPTH_HD) ? '0 : head_inc[HW-1:0];

    res_ok    = 1'b0;
    do_add    = 1'b0;
    do_take   = 1'b0;
    do_finish = 1'b0;
    if (hit) begin
      case (op)
        OP_ADD: begin
          res_ok = has_room;
          do_add = has_room;
        end
        OP_SPACE: res_ok = has_room;
        OP_READY: res_ok = !lock_sel && nonempty;
        OP_TAKE: begin
          res_ok  = !lock_sel && nonempty;
          do_take = !lock_sel && nonempty;
        end
        OP_FINISH: begin
          res_ok    = 1'b1;
          do_finish = 1'b1;
        end
        default: res_ok = 1'b0;
      endcase
    end

    ram_addr = AW'(qi) * AW'(QUEUE_DEPTH) + AW'(do_take ? head_sel : tail_slot);
  end

  lstq_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (TOTAL)
  ) u_store (
    .clk   (clk),
    .we    (accept && do_add),
    .re    (accept && do_take),
    .addr  (ram_addr),
    .wdata (task_handle),
    .rdata (ram_rdata)
  );

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled       <= 1'b0;
      active_queues <= ACTIVE_RESET;
      for (int i = 0; i < CAP_REGS; i++) begin
        cap_reg[i] <= CAP_RESET;
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i]   <= '0;
        count[i]  <= '0;
        locked[i] <= 1'b0;
      end
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ENABLED: enabled       <= cfg_wdata[0];
          CFG_ACTIVE:  active_queues <= cfg_wdata[ACTIVE_W-1:0];
          CFG_CAP_Q0:  cap_reg[0]    <= cfg_wdata;
          CFG_CAP_Q1:  cap_reg[1]    <= cfg_wdata;
          CFG_CAP_Q2:  cap_reg[2]    <= cfg_wdata;
          CFG_CAP_Q3:  cap_reg[3]    <= cfg_wdata;
          default: ;
        endcase
      end

      if (accept) begin
        if (do_add) begin
          count[qi] <= cnt_sel + CNT_W'(1);
        end
        if (do_take) begin
          count[qi] <= cnt_sel - CNT_W'(1);
          head[qi]  <= head_next;
          if (qi != '0) begin
            locked[qi] <= 1'b1;
          end
        end
        if (do_finish) begin
          locked[qi] <= 1'b0;
        end
      end

      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok   <= res_ok;
      s1_take <= do_take;
      s1_qi   <= qi;
    end
    if (s1_adv) begin
      out_ok     <= s1_ok;
      out_handle <= s1_take ? ram_rdata : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - HANDLE_W - 1)'(0), out_handle, out_ok};

  `LSTQ_ASSERT(a_q0_never_locked, !locked[0], "unordered queue got locked")
  `LSTQ_ASSERT_IMPL(a_fail_no_handle, out_valid && !out_ok, out_handle == '0, "handle on fail")
  `LSTQ_ASSERT_IMPL(a_take_locks, s1_valid && s1_take && (s1_qi != '0), locked[s1_qi], "take did not lock")
  `LSTQ_ASSERT_NEXT(a_finish_unlocks, accept && do_finish, !locked[$past(qi)], "finish did not unlock")

  for (genvar gq = 0; gq < NUM_QUEUES; gq++) begin : g_chk
    `LSTQ_ASSERT(a_count_bound, count[gq] <= CNT_W'(QUEUE_DEPTH), "queue count over depth")
  end

endmodule

`default_nettype wire

/* design/lstq_ram.sv */
// ----------------------------------------------------------------------------
// lstq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lstq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* tb/locked_sequence_task_queues_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// locked_sequence_task_queues_unit_tb
// Checks the task queue unit against a cycle-free model of its queues, locks
// and registers. A short directed run goes through each operation and corner
// (full, empty, locked, unknown codes, bad queue ids), then random requests
// run under several register settings with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module locked_sequence_task_queues_unit_tb;
  import lstq_pkg::*;

  localparam int NQ        = 4;
  localparam int DEPTH     = 16;
  localparam int LIMIT     = 300000;
  localparam int TAIL_WAIT = 8;

  // operation codes with no meaning, and register indexes with no register
  localparam logic [OP_W-1:0]      OP_UNDEF_LO  = 3'd5;
  localparam logic [OP_W-1:0]      OP_UNDEF_HI  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [HANDLE_W-1:0] hnd;
    logic [QID_W-1:0]    qid;
    logic [OP_W-1:0]     op;
  } sched_item_t;

  typedef struct packed {
    logic                ok;
    logic [HANDLE_W-1:0] hnd;
  } sched_result_t;

  // Queue model plus the list of results still owed by the block
  class queue_sched_board;
    bit                  en;
    logic [ACTIVE_W-1:0] act_reg;
    logic [CAP_REG_W-1:0] cap_reg[CAP_REGS];
    logic [HANDLE_W-1:0] slots[NQ][DEPTH];
    int                  head[NQ];
    int                  fill[NQ];
    bit                  locked[NQ];
    sched_result_t       owed_q[$];

    function new();
      en      = 1'b0;
      act_reg = ACTIVE_RESET;
      for (int i = 0; i < CAP_REGS; i++) cap_reg[i] = CAP_RESET;
      for (int i = 0; i < NQ; i++) begin
        head[i]   = 0;
        fill[i]   = 0;
        locked[i] = 1'b0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_ENABLED: en = val[0];
        CFG_ACTIVE:  act_reg = val[ACTIVE_W-1:0];
        CFG_CAP_Q0, CFG_CAP_Q1, CFG_CAP_Q2, CFG_CAP_Q3: begin
          cap_reg[int'(idx) - int'(CFG_CAP_Q0)] = val;
        end
        default: ;
      endcase
    endfunction

    function void note_item(sched_item_t item);
      sched_result_t r;
      int lim;
      int cap;
      int q;
      r   = '0;
      lim = (int'(act_reg) > NQ) ? NQ : int'(act_reg);
      if (en && int'(item.qid) < lim) begin
        q   = int'(item.qid);
        cap = (q < CAP_REGS) ? int'(cap_reg[q]) : DEPTH;
        if (cap > DEPTH) cap = DEPTH;
        case (item.op)
          OP_ADD: begin
            if (fill[q] < cap) begin
              slots[q][(head[q] + fill[q]) % DEPTH] = item.hnd;
              fill[q]++;
              r.ok = 1'b1;
            end
          end
          OP_SPACE: r.ok = (fill[q] < cap);
          OP_READY: r.ok = (!locked[q] && fill[q] > 0);
          OP_TAKE: begin
            // an empty take leaves the lock alone
            if (!locked[q] && fill[q] > 0) begin
              r.hnd   = slots[q][head[q]];
              head[q] = (head[q] + 1) % DEPTH;
              fill[q]--;
              if (q != 0) locked[q] = 1'b1;
              r.ok = 1'b1;
            end
          end
          OP_FINISH: begin
            locked[q] = 1'b0;
            r.ok      = 1'b1;
          end
          default: ;
        endcase
      end
      owed_q.push_back(r);
    endfunction

    function string check_result(logic ok, logic [HANDLE_W-1:0] hnd);
      sched_result_t e;
      if (owed_q.size() == 0)
        return $sformatf("result ok=%0b handle=%h with nothing outstanding", ok, hnd);
      e = owed_q.pop_front();
      if (ok !== e.ok || hnd !== e.hnd)
        return $sformatf("ok %0b (want %0b), handle %h (want %h)", ok, e.ok, hnd, e.hnd);
      return "";
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [2:0] operation, [10:3] queue_id, [26:11] task_handle, [31:27] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [0] ok, [16:1] out_handle, [23:17] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  queue_sched_board board = new();
  int errors = 0;
  int cycles = 0;
  int stall_left = 0;

  locked_sequence_task_queues_unit #(
    .NUM_QUEUES (NQ),
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output stalls: stall rate and length change with the cycle count
  always @(posedge clk) begin
    int pct;
    case (cycles[10:9])
      2'd0: pct = 0;
      2'd1: pct = 10;
      2'd2: pct = 45;
      default: pct = 4;
    endcase
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < pct) begin
      stall_left    <= (cycles[10:9] == 2'd3) ? $urandom_range(8, 16) : $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    string why;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      why = board.check_result(m_axis_tdata[0], m_axis_tdata[HANDLE_W:1]);
      if (why != "") report_mismatch(why);
    end
  end

  function automatic sched_item_t mk_item(logic [OP_W-1:0] op, logic [QID_W-1:0] qid,
                                          logic [HANDLE_W-1:0] hnd);
    sched_item_t it;
    it.op  = op;
    it.qid = qid;
    it.hnd = hnd;
    return it;
  endfunction

  // add_w sets how hard the queues are pushed toward full
  function automatic sched_item_t rand_item(int add_w);
    sched_item_t it;
    int r;
    r = $urandom_range(0, add_w + 58);
    if (r < add_w)           it.op = OP_ADD;
    else if (r < add_w + 25) it.op = OP_TAKE;
    else if (r < add_w + 40) it.op = OP_FINISH;
    else if (r < add_w + 48) it.op = OP_SPACE;
    else if (r < add_w + 56) it.op = OP_READY;
    else                     it.op = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    it.qid = ($urandom_range(0, 9) == 0) ? QID_W'($urandom_range(0, 255))
                                         : QID_W'($urandom_range(0, NQ));
    case ($urandom_range(0, 15))
      0:       it.hnd = '0;
      1:       it.hnd = '1;
      default: it.hnd = HANDLE_W'($urandom_range(0, 65535));
    endcase
    return it;
  endfunction

  task automatic send_item(input sched_item_t item);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - $bits(sched_item_t)){1'b0}}, item};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_item(item);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // writes all six registers, in index order, once the block is idle
  task automatic apply_config(input logic [CFG_DATA_W-1:0] en, act, c0, c1, c2, c3);
    logic [CFG_DATA_W-1:0] vals[6];
    vals = '{en, act, c0, c1, c2, c3};
    drain();
    for (int i = 0; i < 6; i++) write_reg(CFG_IDX_W'(i), vals[i]);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n, input int add_w, input bit gaps);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int i = 0; i < n; i++) begin
      if (gaps && burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(1, 8);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      send_item(rand_item(add_w));
      if (burst_left > 0) burst_left--;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // still disabled out of reset
    send_item(mk_item(OP_ADD, 8'd0, 16'h5A5A));

    drain();
    write_reg(CFG_SPARE_LO, 5'h1F);
    write_reg(CFG_SPARE_HI, 5'h1F);
    cfg_we <= 1'b0;
    apply_config(5'd1, 5'd4, 5'd1, 5'd2, 5'd16, 5'd0);

    send_item(mk_item(OP_ADD,    8'd0, 16'h0000));
    send_item(mk_item(OP_ADD,    8'd0, 16'hFFFF));   // q0 full
    send_item(mk_item(OP_SPACE,  8'd0, 16'h0000));
    send_item(mk_item(OP_READY,  8'd0, 16'h0000));
    send_item(mk_item(OP_TAKE,   8'd0, 16'h0000));   // unordered: no lock
    send_item(mk_item(OP_TAKE,   8'd0, 16'h0000));   // empty
    send_item(mk_item(OP_ADD,    8'd1, 16'hFFFF));
    send_item(mk_item(OP_ADD,    8'd1, 16'h1234));
    send_item(mk_item(OP_ADD,    8'd1, 16'h4321));   // q1 full
    send_item(mk_item(OP_TAKE,   8'd1, 16'h0000));   // locks q1
    send_item(mk_item(OP_READY,  8'd1, 16'h0000));
    send_item(mk_item(OP_TAKE,   8'd1, 16'h0000));   // locked
    send_item(mk_item(OP_FINISH, 8'd1, 16'h0000));
    send_item(mk_item(OP_TAKE,   8'd1, 16'h0000));
    send_item(mk_item(OP_FINISH, 8'd1, 16'h0000));
    send_item(mk_item(OP_TAKE,   8'd2, 16'h0000));   // empty take, must not lock
    send_item(mk_item(OP_ADD,    8'd2, 16'hA5A5));
    send_item(mk_item(OP_READY,  8'd2, 16'h0000));
    send_item(mk_item(OP_SPACE,  8'd3, 16'h0000));   // zero capacity
    send_item(mk_item(OP_ADD,    8'd3, 16'hFFFF));
    send_item(mk_item(OP_FINISH, 8'd3, 16'h0000));   // finish while unlocked
    send_item(mk_item(OP_ADD,    8'd4, 16'h1111));   // id == active count
    send_item(mk_item(OP_FINISH, 8'd255, 16'h0000));
    send_item(mk_item(OP_UNDEF_LO, 8'd0, 16'h0000));
    send_item(mk_item(OP_UNDEF_HI, 8'd2, 16'h0000));

    apply_config(5'd1, 5'd4, 5'd16, 5'd16, 5'd16, 5'd16);
    run_random(250, 45, 1'b1);
    apply_config(5'd1, 5'd4, 5'd1, 5'd2, 5'd0, 5'd3);
    run_random(200, 30, 1'b0);
    // active above the queue count, two capacities above the depth
    apply_config(5'd1, 5'd7, 5'd31, 5'd17, 5'd5, 5'd16);
    run_random(250, 35, 1'b1);
    // bit 0 clear: disabled
    apply_config(5'h1E, 5'd4, 5'd16, 5'd16, 5'd16, 5'd16);
    run_random(60, 30, 1'b1);
    apply_config(5'd1, 5'd0, 5'd16, 5'd16, 5'd16, 5'd16);
    run_random(60, 30, 1'b1);
    apply_config(5'd1, 5'd2, CFG_DATA_W'($urandom_range(0, 31)),
                 CFG_DATA_W'($urandom_range(0, 31)), CFG_DATA_W'($urandom_range(0, 31)),
                 CFG_DATA_W'($urandom_range(0, 31)));
    run_random(200, 35, 1'b1);
    // upper bits of the enable value are dropped and bit 0 is clear: disabled
    apply_config(5'd12, 5'd4, 5'd4, 5'd16, 5'd8, 5'd2);
    run_random(230, 40, 1'b1);

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/lstq_pkg.sv
design/lstq_ram.sv
design/locked_sequence_task_queues_unit.sv
tb/locked_sequence_task_queues_unit_tb.sv
